// ===== rtl/slcg_pkg.sv =====
// shared constants and types for the shuffled lcg random generator
`timescale 1ns / 1ps

package slcg_pkg;

    localparam int     LCG_A          = 16807;
    localparam longint LCG_M          = 64'd2147483647;
    localparam int     TABLE_SIZE_DEF = 32;
    // warm-up steps beyond the table fill, less the one step that fills entry 0
    localparam int     WARMUP_EXTRA   = 7;

    typedef logic [30:0] t_word;

endpackage

// ===== rtl/slcg_step.sv =====
// one multiplicative congruential step: 16807 * w mod (2^31 - 1), product registered, fold combinational
`timescale 1ns / 1ps

module slcg_step (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_word,
    output slcg_pkg::t_word  o_next
);

    logic [45:0] r_prod;
    logic [31:0] fold;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 46'(i_word) * 46'(slcg_pkg::LCG_A);
        end
    end

    // 2^31 is 1 mod m, so the high part folds onto the low part
    always_comb begin
        fold = 32'(r_prod[45:31]) + {1'b0, r_prod[30:0]};
        if (fold >= 32'(slcg_pkg::LCG_M)) begin
            o_next = 31'(fold - 32'(slcg_pkg::LCG_M));
        end else begin
            o_next = fold[30:0];
        end
    end

endmodule

// ===== rtl/shuffled_lcg_random_generator.sv =====
// Shuffled multiplicative random generator (multiplier 16807, modulus 2^31-1,
// shuffle table of TABLE_SIZE entries).
// Input channel i_valid/o_ready carries one draw request: i_func = 0 draws with
// the stored word, i_func = 1 first loads i_seed_word. Output channel
// o_valid/i_ready returns one o_random_value per request.
// All arithmetic runs through one multiply-and-fold step unit under a
// small sequencer; the block takes no new item while a request is in progress.
// A plain draw passes through S_MUL, S_RED, S_IDX and S_FIN, and o_ready returns
// the cycle the result is registered, so a new draw waits until the last is done.
// A request that needs initialization (first draw after reset, a word at or
// below zero, or a zero shuffle output) first runs the warm-up and table fill.
// Reset clears the stored word and the shuffle output, so the first draw
// always initializes; the table itself is not cleared.
// A finished result sits in an output register; a new item is accepted while
// it waits, and a later result holds in the sequencer until the receiver
// takes the earlier one.
`timescale 1ns / 1ps

module shuffled_lcg_random_generator #(
    parameter int TABLE_SIZE = slcg_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic signed [31:0] i_seed_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_random_value
);

    localparam int     IW        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int     CW        = $clog2(TABLE_SIZE + slcg_pkg::WARMUP_EXTRA + 1);
    localparam int     RB        = IW + 1;
    localparam longint IDX_DIV   = 64'd1 + (slcg_pkg::LCG_M - 64'd1) / TABLE_SIZE;
    localparam longint IDX_RECIP = (64'd1 << 31) / IDX_DIV;

    localparam logic [30:0]   DIV_C     = 31'(IDX_DIV);
    localparam logic [RB-1:0] RECIP_C   = RB'(IDX_RECIP);
    localparam logic [CW-1:0] CNT_START = CW'(TABLE_SIZE + slcg_pkg::WARMUP_EXTRA);
    localparam logic [CW-1:0] CNT_TAB   = CW'(TABLE_SIZE);
    localparam logic [RB-1:0] TAB_N     = RB'(TABLE_SIZE);
    localparam logic [RB-1:0] IDX_LAST  = RB'(TABLE_SIZE - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_IDX  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic            r_init;
    logic [CW-1:0]   r_cnt;
    logic [31:0]     r_word;
    slcg_pkg::t_word r_shuffle_out;
    slcg_pkg::t_word r_gen_word;
    logic [RB-1:0]   r_q0;
    logic [30:0]     r_qd;
    slcg_pkg::t_word r_rd_data;
    logic            r_out_valid;
    slcg_pkg::t_word r_out_value;

    slcg_pkg::t_word r_table [TABLE_SIZE];

    logic               accept;
    logic signed [31:0] w_sel;
    logic               need_init;
    logic [31:0]        w_start;
    slcg_pkg::t_word    step_next;
    logic               step_en;
    logic [30+RB:0]     q0_prod;
    logic [30+RB:0]     qd_prod;
    logic [30:0]        rem;
    logic [RB-1:0]      q1;
    logic [RB-1:0]      idx;
    logic               out_free;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    slcg_pkg::t_word    wr_data;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_random_value = r_out_value;
    assign out_free = !r_out_valid || i_ready;
    assign step_en  = (r_state == S_MUL);

    // word selection and the forced-positive start word
    always_comb begin
        w_sel     = i_func ? i_seed_word : $signed({1'b0, r_gen_word});
        need_init = w_sel[31] || (w_sel == 32'sd0) || (r_shuffle_out == 31'd0);
        if (w_sel[31]) begin
            w_start = ~w_sel + 32'd1;
        end else if (need_init) begin
            w_start = 32'd1;
        end else begin
            w_start = w_sel;
        end
    end

    slcg_step u_step (
        .i_clk  (i_clk),
        .i_en   (step_en),
        .i_word (r_word),
        .o_next (step_next)
    );

    // table index: reciprocal estimate, then one correction and a clamp
    always_comb begin
        q0_prod = (31 + RB)'(r_shuffle_out) * (31 + RB)'(RECIP_C);
        qd_prod = (31 + RB)'(r_q0) * (31 + RB)'(DIV_C);
        rem     = r_shuffle_out - r_qd;
        q1      = (rem >= DIV_C) ? r_q0 + RB'(1) : r_q0;
        idx     = (q1 >= TAB_N) ? IDX_LAST : q1;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx[IW-1:0];
        wr_data = r_word[30:0];
        if (r_state == S_RED && r_init && r_cnt < CNT_TAB) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[IW-1:0];
            wr_data = step_next;
        end else if (r_state == S_IDX) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (r_state == S_IDX) begin
            r_rd_data <= r_table[idx[IW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_state = r_init ? S_MUL : S_IDX;
            end
            S_IDX: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_init        <= 1'b0;
            r_shuffle_out <= '0;
            r_gen_word    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_init <= need_init;
                    end
                end
                S_RED: begin
                    if (r_init && r_cnt == '0) begin
                        r_init        <= 1'b0;
                        r_shuffle_out <= step_next;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_shuffle_out <= r_rd_data;
                        r_gen_word    <= r_word[30:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_word <= w_start;
                    r_cnt  <= CNT_START;
                end
            end
            S_MUL: begin
                r_q0 <= q0_prod[30+RB:31];
            end
            S_RED: begin
                r_word <= {1'b0, step_next};
                r_qd   <= qd_prod[30:0];
                if (r_init && r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_value <= r_rd_data;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("ready stayed high after an accepted item");

    a_step_below_modulus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> (step_next != 31'h7FFFFFFF))
        else $error("step result reached the modulus");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init && r_state != S_IDLE) |-> (r_cnt <= CNT_START))
        else $error("warm-up counter out of range");

    a_out_below_modulus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_random_value != 31'h7FFFFFFF))
        else $error("result equals the modulus");
`endif

endmodule

// ===== tb/tb_top.sv =====
// testbench for the shuffled lcg random generator: directed and random draws, scoreboard check
`timescale 1ns / 1ps

module tb_top;

    localparam int     TBL_N   = slcg_pkg::TABLE_SIZE_DEF;
    localparam longint SCH_Q   = 127773;
    localparam longint SCH_R   = 2836;
    localparam longint IDX_DIV = 1 + (slcg_pkg::LCG_M - 1) / TBL_N;
    localparam int     N_ITEMS = 1225;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_func;
    logic signed [31:0] i_seed_word;
    logic               o_valid;
    logic               i_ready;
    logic [30:0]        o_random_value;

    int hold_request = 0;
    bit no_idle = 1'b0;

    // tracks generator word, shuffle output and table; queues the values each draw returns
    class lcg_draw_book;
        logic [31:0]     word;
        slcg_pkg::t_word shuffle_reg;
        slcg_pkg::t_word tbl[TBL_N];
        slcg_pkg::t_word pending[$];
        int              errors;

        function new();
            word = '0;
            shuffle_reg = '0;
            errors = 0;
            foreach (tbl[i]) tbl[i] = '0;
        endfunction

        function longint next_schrage(longint w);
            longint q, r, n;
            q = w / SCH_Q;
            r = w - q * SCH_Q;
            n = slcg_pkg::LCG_A * r - SCH_R * q;
            if (n < 0) n += slcg_pkg::LCG_M;
            return n;
        endfunction

        function void note_request(logic func, logic signed [31:0] seed);
            longint w;
            longint idx;
            int     i;
            w = longint'($signed(word));
            if (func) w = longint'(seed);
            if (w <= 0 || shuffle_reg == 0) begin
                // negate into range; zero, or a positive word, becomes one
                w = (-w < 1) ? 1 : -w;
                for (i = TBL_N + slcg_pkg::WARMUP_EXTRA; i >= 0; i--) begin
                    w = next_schrage(w);
                    if (i < TBL_N) tbl[i] = slcg_pkg::t_word'(w);
                end
                shuffle_reg = tbl[0];
            end
            w = next_schrage(w);
            idx = longint'(shuffle_reg) / IDX_DIV;
            if (idx >= TBL_N) idx = TBL_N - 1;
            shuffle_reg = tbl[idx];
            tbl[idx] = slcg_pkg::t_word'(w);
            word = w[31:0];
            pending = {pending, shuffle_reg};
        endfunction

        function void check_result(slcg_pkg::t_word actual);
            slcg_pkg::t_word exp_val;
            if (pending.size() == 0) begin
                $display("%0t: unexpected random_value %0d, expected none", $time, actual);
                errors++;
                return;
            end
            exp_val = pending.pop_front();
            if (actual !== exp_val) begin
                $display("%0t: random_value mismatch, expected %0d, got %0d",
                         $time, exp_val, actual);
                errors++;
            end
        endfunction
    endclass

    lcg_draw_book book = new();

    shuffled_lcg_random_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_seed_word    (i_seed_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value)
    );

    always #6 i_clk = ~i_clk;

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_request(input logic func, input logic signed [31:0] seed);
        i_valid     <= 1'b1;
        i_func      <= func;
        i_seed_word <= seed;
        @(posedge i_clk);
        while (!(i_valid && o_ready)) @(posedge i_clk);
        book.note_request(func, seed);
    endtask

    task automatic issue(input logic func, input logic signed [31:0] seed);
        int gap;
        offer_request(func, seed);
        gap = idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // mostly plain draws; reloads are positive words, arbitrary words or edge words
    function automatic void random_fields(output logic func, output logic signed [31:0] seed);
        int pick;
        pick = $urandom_range(0, 99);
        seed = $urandom;
        func = (pick < 30);
        if (pick < 12) begin
            seed = $urandom_range(1, 32'h7FFF_FFFF);
        end else if (pick >= 22 && pick < 30) begin
            case ($urandom_range(0, 6))
                0: seed = 32'sh0000_0000;
                1: seed = 32'sh0000_0001;
                2: seed = -32'sd1;
                3: seed = 32'sh7FFF_FFFF;
                4: seed = 32'sh8000_0000;
                5: seed = 32'sh7FFF_FFFE;
                default: seed = 32'sh8000_0001;
            endcase
        end
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready) book.check_result(o_random_value);
            if (!i_rst_n || hold_request > 0) begin
                i_ready <= 1'b0;
                if (hold_request > 0) hold_request--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall_left = idle_length();
            end
        end
    end

    initial begin : stimulus
        logic               f;
        logic signed [31:0] s;
        int                 k;
        int                 j;
        i_valid     <= 1'b0;
        i_func      <= 1'b0;
        i_seed_word <= '0;
        i_rst_n     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first draw initializes from the cleared word
        issue(1'b0, 32'sh5A5A_A5A5);
        issue(1'b0, 32'sh0000_0000);
        issue(1'b1, 32'sh0000_0000);
        issue(1'b1, -32'sd1);
        issue(1'b1, 32'sh8000_0000);
        issue(1'b0, -32'sd1);
        // positive word with a live shuffle output skips initialization
        issue(1'b1, 32'sh0000_0001);
        issue(1'b1, 32'sh7FFF_FFFE);
        // word equal to the modulus steps to zero, next draw reinitializes
        issue(1'b1, 32'sh7FFF_FFFF);
        issue(1'b0, 32'sh7FFF_FFFF);
        issue(1'b1, 32'sh7FFF_FFFF);
        issue(1'b1, 32'sh7FFF_FFFF);
        issue(1'b1, 32'sh7FFF_FFFF);
        issue(1'b0, 32'sh0000_0000);
        issue(1'b1, 32'sh8000_0001);
        issue(1'b1, 32'shFFFF_FFFE);
        for (j = 0; j < 8; j++) issue(1'b0, $urandom);

        k = 0;
        while (k < N_ITEMS) begin
            if (k == 400) begin
                // receiver holds off while items keep coming until the input stalls
                hold_request = 250;
                for (j = 0; j < 12; j++) begin
                    random_fields(f, s);
                    offer_request(f, s);
                end
                k += 12;
                i_valid <= 1'b0;
                while (book.pending.size() != 0) @(posedge i_clk);
            end else begin
                no_idle = (k >= 700 && k < 850);
                random_fields(f, s);
                issue(f, s);
                k++;
            end
        end
        no_idle = 1'b0;

        i_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (book.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== shuffled_lcg_random_generator.f =====
rtl/slcg_pkg.sv
rtl/slcg_step.sv
rtl/shuffled_lcg_random_generator.sv
tb/tb_top.sv
